FILE: rtl/core/wrms_pkg.sv
// ----------------------------------------------------------------------------
// Windowed RMS loudness meter package
// Shared widths, payload words, register codes and sequencer states.
// ----------------------------------------------------------------------------
package wrms_pkg;

  localparam int CHANNELS    = 2;
  localparam int CH_W        = 1;
  localparam int HIST_DEPTH  = 32768;
  localparam int HIST_AW     = 15;
  localparam int SAMPLE_BITS = 24;
  localparam int SQ_SHIFT    = 2 * SAMPLE_BITS - 32;
  localparam int HIST_W      = 32;
  localparam int SUM_W       = 47;
  localparam int MS_W        = 36;
  localparam int ACC_W       = 53;
  localparam int ROOT_W      = 28;
  localparam int MIX_W       = 45;
  localparam int OUT_W       = 24;

  localparam int MUL_A_W     = 47;
  localparam int MUL_B_W     = 25;
  localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

  localparam int SQ_IN_W     = 56;
  localparam int SQ_OUT_W    = SQ_IN_W / 2;
  localparam int SQ_CW       = $clog2(SQ_OUT_W + 1);

  localparam int CFG_AW      = 5;
  localparam int CFG_DW      = 32;

  localparam logic [16:0]      LINK_FULL = 17'h10000;
  localparam logic [MS_W-1:0]  MS_MAX    = '1;
  localparam logic [OUT_W-1:0] OUT_MAX   = '1;

  typedef enum logic [2:0] {
    REG_WINDOW_LENGTH,
    REG_AVG_COEFF,
    REG_CHANNEL_ENABLE,
    REG_WEIGHT_LEFT,
    REG_WEIGHT_RIGHT,
    REG_LINK_LEFT,
    REG_LINK_RIGHT,
    REG_OUTPUT_GAIN
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_RC,
    ST_RD,
    ST_SQ,
    ST_SUB,
    ST_MS,
    ST_WT,
    ST_OWN,
    ST_LOUD,
    ST_LGAIN,
    ST_MIXA,
    ST_MIXB,
    ST_CGAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
  } in_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] loudness_rms;
    logic [OUT_W-1:0] out_left;
    logic [OUT_W-1:0] out_right;
  } out_word_t;

endpackage

FILE: rtl/core/windowed_rms_loudness_meter.sv
// ----------------------------------------------------------------------------
// Windowed RMS loudness meter
// Per-channel sliding-window mean square, weighted loudness root, link and gain.
// ----------------------------------------------------------------------------
// One word in gives one word out. The time a word takes, plus any output
// stall, is set by the shared bit-serial multiplier (one multiplier bit per
// cycle up to the top set bit, thirteen products per word with both channels
// enabled) and the serial square root (28 steps, three roots per word); a
// disabled channel skips its share. After reset, and after a channel enable
// bit goes from 0 to 1, the history ring of each channel concerned is cleared
// in one pass over all 32768 entries; a window_length write rebuilds the
// window sums. No input word is taken during either pass, while register
// writes are taken at any time.
// ----------------------------------------------------------------------------
module windowed_rms_loudness_meter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  wrms_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output wrms_pkg::out_word_t           out_word_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wrms_pkg::CFG_AW-1:0]   paddr,
  input  logic [wrms_pkg::CFG_DW-1:0]   pwdata,
  output logic [wrms_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import wrms_pkg::*;

  function automatic logic [OUT_W-1:0] gain_sat(input logic [MUL_P_W-1:0] p);
    logic [MUL_P_W-1:0] v;
    v = p >> 12;
    return (v > MUL_P_W'(OUT_MAX)) ? OUT_MAX : v[OUT_W-1:0];
  endfunction

  state_e state_q, state_d;

  logic [14:0] wlen_q;
  logic [24:0] coeff_q;
  logic [1:0]  en_q;
  logic [15:0] wgt_q  [CHANNELS];
  logic [16:0] link_q [CHANNELS];
  logic [15:0] gain_q;

  logic [SUM_W-1:0]   sum_q [CHANNELS];
  logic [HIST_AW-1:0] wp_q;
  logic [CH_W-1:0]    ch_q;
  logic               issued_q;
  logic [HIST_AW:0]   cnt_q;
  logic               rd_vld_q;
  logic [1:0]         clr_mask_q;
  logic               rc_pend_q;

  logic signed [SAMPLE_BITS-1:0] samp_q [CHANNELS];
  logic [SUM_W:0]     tmp_q;
  logic [MS_W-1:0]    ms_q  [CHANNELS];
  logic [ACC_W-1:0]   acc_q;
  logic [ROOT_W-1:0]  own_q [CHANNELS];
  logic [ROOT_W-1:0]  loud_q;
  logic [MIX_W-1:0]   mix_q;
  logic [OUT_W-1:0]   loud_out_q;
  logic [OUT_W-1:0]   outs_q [CHANNELS];

  logic               out_valid_q;
  out_word_t          out_word_q;

  logic [HIST_W-1:0]  rdata_q [CHANNELS];
  logic [CHANNELS-1:0] mem_we;
  logic [HIST_AW-1:0] mem_waddr, mem_raddr;
  logic [HIST_W-1:0]  mem_wdata;

  logic               cfg_wr;
  reg_idx_e           cfg_idx;
  logic [1:0]         rising;
  logic               kick;
  logic [HIST_AW-1:0] win_eff;
  logic [HIST_AW-1:0] tail;
  logic               go_clr, go_rc, accept;
  logic               ch_en, last_ch;
  logic [CH_W-1:0]    ch_nx;
  logic [16:0]        lk, lk_inv;
  logic signed [SAMPLE_BITS-1:0] samp_c;
  logic [SAMPLE_BITS-1:0] mag;
  logic [HIST_W-1:0]  sq;
  logic [MUL_P_W-1:0] ms_full;
  logic               clr_end, rc_end, out_free;

  logic               mul_start, mul_done, sq_start, sq_done;
  logic               mul_go, sq_go;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [SQ_IN_W-1:0] sq_x;
  logic [SQ_OUT_W-1:0] sq_root;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);
  assign rising  = (cfg_wr && cfg_idx == REG_CHANNEL_ENABLE) ? (pwdata[1:0] & ~en_q) : 2'b00;
  assign kick    = (cfg_wr && cfg_idx == REG_WINDOW_LENGTH) || (rising != 2'b00);

  assign win_eff = (wlen_q == '0) ? HIST_AW'(1) : wlen_q;
  assign tail    = wp_q - win_eff;

  assign go_clr     = (clr_mask_q != 2'b00);
  assign go_rc      = !go_clr && rc_pend_q && !kick;
  assign in_stall_o = !(state_q == ST_IDLE && !go_clr && !rc_pend_q && !cfg_wr);
  assign accept     = in_valid_i && !in_stall_o;

  assign ch_en   = en_q[ch_q];
  assign last_ch = (ch_q == CH_W'(CHANNELS - 1));
  assign ch_nx   = last_ch ? '0 : CH_W'(ch_q + 1'b1);

  assign lk     = (link_q[ch_q] > LINK_FULL) ? LINK_FULL : link_q[ch_q];
  assign lk_inv = LINK_FULL - lk;

  assign samp_c  = samp_q[ch_q];
  assign mag     = samp_c[SAMPLE_BITS-1] ? SAMPLE_BITS'(-samp_c) : SAMPLE_BITS'(samp_c);
  assign sq      = mul_p[SQ_SHIFT +: HIST_W];
  assign ms_full = mul_p >> 24;

  assign clr_end  = (cnt_q[HIST_AW-1:0] == '1);
  assign rc_end   = (cnt_q > {1'b0, win_eff}) && !rd_vld_q;
  assign out_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (go_clr) begin
          state_d = ST_CLR;
        end else if (go_rc) begin
          state_d = ST_RC;
        end else if (accept) begin
          state_d = ST_RD;
        end
      end
      ST_CLR: begin
        if (kick || clr_end) state_d = ST_IDLE;
      end
      ST_RC: begin
        if (kick || rc_end) state_d = ST_IDLE;
      end
      ST_RD: state_d = ST_SQ;
      ST_SQ: begin
        if (!ch_en) begin
          state_d = last_ch ? ST_LOUD : ST_SQ;
        end else if (mul_done) begin
          state_d = ST_SUB;
        end
      end
      ST_SUB: state_d = ST_MS;
      ST_MS: begin
        if (mul_done) state_d = ST_WT;
      end
      ST_WT: begin
        if (mul_done) state_d = ST_OWN;
      end
      ST_OWN: begin
        if (sq_done) state_d = last_ch ? ST_LOUD : ST_SQ;
      end
      ST_LOUD: begin
        if (en_q == 2'b00 || sq_done) state_d = ST_LGAIN;
      end
      ST_LGAIN: begin
        if (mul_done) state_d = ST_MIXA;
      end
      ST_MIXA: begin
        if (!ch_en) begin
          state_d = last_ch ? ST_DONE : ST_MIXA;
        end else if (mul_done) begin
          state_d = ST_MIXB;
        end
      end
      ST_MIXB: begin
        if (mul_done) state_d = ST_CGAIN;
      end
      ST_CGAIN: begin
        if (mul_done) state_d = last_ch ? ST_DONE : ST_MIXA;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // unit controls, operands and history writes
  always_comb begin
    mul_go    = 1'b0;
    sq_go     = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    sq_x      = '0;
    mem_we    = '0;
    mem_waddr = wp_q;
    mem_wdata = sq;
    mem_raddr = tail;
    case (state_q)
      ST_CLR: begin
        mem_we    = clr_mask_q;
        mem_waddr = cnt_q[HIST_AW-1:0];
        mem_wdata = '0;
      end
      ST_RC: begin
        mem_raddr = wp_q - cnt_q[HIST_AW-1:0];
      end
      ST_SQ: begin
        mul_go = ch_en;
        mul_a  = MUL_A_W'(mag);
        mul_b  = MUL_B_W'(mag);
        if (mul_done) begin
          mem_we[ch_q] = 1'b1;
        end
      end
      ST_MS: begin
        mul_go = 1'b1;
        mul_a  = sum_q[ch_q];
        mul_b  = coeff_q;
      end
      ST_WT: begin
        mul_go = 1'b1;
        mul_a  = MUL_A_W'(ms_q[ch_q]);
        mul_b  = MUL_B_W'(wgt_q[ch_q]);
      end
      ST_OWN: begin
        sq_go = 1'b1;
        sq_x  = SQ_IN_W'({ms_q[ch_q], 16'h0000});
      end
      ST_LOUD: begin
        sq_go = (en_q != 2'b00);
        sq_x  = SQ_IN_W'({acc_q, 2'b00});
      end
      ST_LGAIN: begin
        mul_go = 1'b1;
        mul_a  = MUL_A_W'(loud_q);
        mul_b  = MUL_B_W'(gain_q);
      end
      ST_MIXA: begin
        mul_go = ch_en;
        mul_a  = MUL_A_W'(loud_q);
        mul_b  = MUL_B_W'(lk);
      end
      ST_MIXB: begin
        mul_go = 1'b1;
        mul_a  = MUL_A_W'(own_q[ch_q]);
        mul_b  = MUL_B_W'(lk_inv);
      end
      ST_CGAIN: begin
        mul_go = 1'b1;
        mul_a  = MUL_A_W'(mix_q[MIX_W-1:16]);
        mul_b  = MUL_B_W'(gain_q);
      end
      default: begin
        mul_go = 1'b0;
      end
    endcase
    mul_start = mul_go && !issued_q;
    sq_start  = sq_go && !issued_q;
  end

  wrms_smul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  wrms_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     (sq_x),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  for (genvar c = 0; c < CHANNELS; c++) begin : g_hist
    logic [HIST_W-1:0] mem [HIST_DEPTH];
    always_ff @(posedge clk_i) begin
      if (mem_we[c]) begin
        mem[mem_waddr] <= mem_wdata;
      end
      rdata_q[c] <= mem[mem_raddr];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      issued_q    <= 1'b0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      clr_mask_q  <= 2'b11;
      rc_pend_q   <= 1'b0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (mul_start || sq_start) begin
        issued_q <= 1'b1;
      end else if (mul_done || sq_done) begin
        issued_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (go_clr) begin
            cnt_q <= '0;
          end else if (go_rc) begin
            cnt_q    <= (HIST_AW+1)'(1);
            rd_vld_q <= 1'b0;
          end
        end
        ST_CLR: cnt_q <= cnt_q + 1'b1;
        ST_RC: begin
          rd_vld_q <= (cnt_q <= {1'b0, win_eff});
          if (cnt_q <= {1'b0, win_eff}) begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_RD: ch_q <= '0;
        ST_SQ: begin
          if (!ch_en) ch_q <= ch_nx;
        end
        ST_OWN: begin
          if (sq_done) ch_q <= ch_nx;
        end
        ST_LGAIN: begin
          if (mul_done) ch_q <= '0;
        end
        ST_MIXA: begin
          if (!ch_en) ch_q <= ch_nx;
        end
        ST_CGAIN: begin
          if (mul_done) ch_q <= ch_nx;
        end
        ST_DONE: begin
          if (out_free) wp_q <= wp_q + 1'b1;
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase

      if (state_q == ST_CLR && clr_end && !kick) begin
        clr_mask_q <= rising;
      end else begin
        clr_mask_q <= clr_mask_q | rising;
      end

      if (cfg_wr && cfg_idx == REG_WINDOW_LENGTH) begin
        rc_pend_q <= 1'b1;
      end else if (state_q == ST_RC && rc_end && !kick) begin
        rc_pend_q <= 1'b0;
      end

      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // window sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sum_q[c] <= '0;
      end
    end else begin
      if (state_q == ST_IDLE && go_rc) begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (en_q[c]) sum_q[c] <= '0;
        end
      end else if (state_q == ST_RC && rd_vld_q) begin
        for (int c = 0; c < CHANNELS; c++) begin
          if (en_q[c]) sum_q[c] <= sum_q[c] + SUM_W'(rdata_q[c]);
        end
      end else if (state_q == ST_SUB) begin
        sum_q[ch_q] <= (tmp_q >= (SUM_W+1)'(rdata_q[ch_q]))
                     ? SUM_W'(tmp_q - (SUM_W+1)'(rdata_q[ch_q])) : '0;
      end
      for (int c = 0; c < CHANNELS; c++) begin
        if (rising[c]) sum_q[c] <= '0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q    <= 15'd19200;
      coeff_q   <= 25'd874;
      en_q      <= 2'b11;
      wgt_q[0]  <= 16'd16384;
      wgt_q[1]  <= 16'd16384;
      link_q[0] <= LINK_FULL;
      link_q[1] <= LINK_FULL;
      gain_q    <= 16'd4096;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WINDOW_LENGTH:  wlen_q    <= pwdata[14:0];
        REG_AVG_COEFF:      coeff_q   <= pwdata[24:0];
        REG_CHANNEL_ENABLE: en_q      <= pwdata[1:0];
        REG_WEIGHT_LEFT:    wgt_q[0]  <= pwdata[15:0];
        REG_WEIGHT_RIGHT:   wgt_q[1]  <= pwdata[15:0];
        REG_LINK_LEFT:      link_q[0] <= pwdata[16:0];
        REG_LINK_RIGHT:     link_q[1] <= pwdata[16:0];
        REG_OUTPUT_GAIN:    gain_q    <= pwdata[15:0];
        default:            gain_q    <= gain_q;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WINDOW_LENGTH:  prdata = CFG_DW'(wlen_q);
      REG_AVG_COEFF:      prdata = CFG_DW'(coeff_q);
      REG_CHANNEL_ENABLE: prdata = CFG_DW'(en_q);
      REG_WEIGHT_LEFT:    prdata = CFG_DW'(wgt_q[0]);
      REG_WEIGHT_RIGHT:   prdata = CFG_DW'(wgt_q[1]);
      REG_LINK_LEFT:      prdata = CFG_DW'(link_q[0]);
      REG_LINK_RIGHT:     prdata = CFG_DW'(link_q[1]);
      REG_OUTPUT_GAIN:    prdata = CFG_DW'(gain_q);
      default:            prdata = '0;
    endcase
  end

  // item datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      samp_q[0] <= in_word_i.sample_left;
      samp_q[1] <= in_word_i.sample_right;
      acc_q     <= '0;
    end
    case (state_q)
      ST_SQ: begin
        if (ch_en && mul_done) begin
          tmp_q <= {1'b0, sum_q[ch_q]} + (SUM_W+1)'(sq);
        end
      end
      ST_MS: begin
        if (mul_done) begin
          ms_q[ch_q] <= (ms_full > MUL_P_W'(MS_MAX)) ? MS_MAX : ms_full[MS_W-1:0];
        end
      end
      ST_WT: begin
        if (mul_done) acc_q <= acc_q + mul_p[ACC_W-1:0];
      end
      ST_OWN: begin
        if (sq_done) own_q[ch_q] <= sq_root;
      end
      ST_LOUD: begin
        if (en_q == 2'b00) begin
          loud_q <= '0;
        end else if (sq_done) begin
          loud_q <= sq_root;
        end
      end
      ST_LGAIN: begin
        if (mul_done) loud_out_q <= gain_sat(mul_p);
      end
      ST_MIXA: begin
        if (!ch_en) begin
          outs_q[ch_q] <= '0;
        end else if (mul_done) begin
          mix_q <= mul_p[MIX_W-1:0];
        end
      end
      ST_MIXB: begin
        if (mul_done) mix_q <= mix_q + mul_p[MIX_W-1:0];
      end
      ST_CGAIN: begin
        if (mul_done) outs_q[ch_q] <= gain_sat(mul_p);
      end
      ST_DONE: begin
        if (out_free) begin
          out_word_q.loudness_rms <= loud_out_q;
          out_word_q.out_left     <= outs_q[0];
          out_word_q.out_right    <= outs_q[1];
        end
      end
      default: begin
        tmp_q <= tmp_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

FILE: rtl/core/wrms_smul.sv
// ----------------------------------------------------------------------------
// Bit-serial multiplier
// Shift-add product, one multiplier bit per cycle, stops at the last set bit.
// ----------------------------------------------------------------------------
module wrms_smul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [wrms_pkg::MUL_A_W-1:0]   a_i,
  input  logic [wrms_pkg::MUL_B_W-1:0]   b_i,
  output logic                           done_o,
  output logic [wrms_pkg::MUL_P_W-1:0]   prod_o
);
  import wrms_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [MUL_P_W-1:0] a_q;
  logic [MUL_B_W-1:0] b_q;
  logic [MUL_P_W-1:0] p_q;
  logic               last;

  assign last = (b_q[MUL_B_W-1:1] == '0);

  always_comb begin
    done_d = busy_q && last;
    busy_d = busy_q && !last;
    if (start_i) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= {{(MUL_P_W-MUL_A_W){1'b0}}, a_i};
      b_q <= b_i;
      p_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        p_q <= p_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

FILE: rtl/core/wrms_sqrt.sv
// ----------------------------------------------------------------------------
// Serial integer square root
// Floor root, one result bit per cycle over SQ_OUT_W steps.
// ----------------------------------------------------------------------------
module wrms_sqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [wrms_pkg::SQ_IN_W-1:0]   x_i,
  output logic                           done_o,
  output logic [wrms_pkg::SQ_OUT_W-1:0]  root_o
);
  import wrms_pkg::*;

  localparam logic [SQ_CW-1:0]   SQ_LAST   = SQ_CW'(SQ_OUT_W - 1);
  localparam logic [SQ_IN_W-1:0] BIT_START = {2'b01, {(SQ_IN_W-2){1'b0}}};

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [SQ_CW-1:0]   cnt_q;
  logic [SQ_IN_W-1:0] x_q, r_q, bit_q;
  logic [SQ_IN_W-1:0] trial;
  logic               last;

  assign trial = r_q + bit_q;
  assign last  = (cnt_q == SQ_LAST);

  always_comb begin
    done_d = busy_q && last;
    busy_d = busy_q && !last;
    if (start_i) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      if (start_i) begin
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      r_q   <= '0;
      bit_q <= BIT_START;
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_q <= x_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[SQ_OUT_W-1:0];

endmodule
